### sv/palette_find_add_nearest_core_assert.svh
// Assertion macros shared by the palette core modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef PALETTE_FIND_ADD_NEAREST_CORE_ASSERT_SVH
`define PALETTE_FIND_ADD_NEAREST_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PFAN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PFAN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/pfan_pkg.sv
// Shared types and constants for the palette find/add/nearest core.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package pfan_pkg;

    // Field widths
    localparam int COLOR_W     = 24;
    localparam int LIMIT_W     = 9;
    localparam int IDX_OUT_W   = 8;
    localparam int KIND_W      = 2;
    localparam int CNT_OUT_W   = 9;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;
    localparam int DIST_W      = 19;

    // Defaults
    localparam int                 PALETTE_DEPTH_DEF = 256;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET       = 9'd256;
    localparam logic [DIST_W-1:0]  DIST_CEILING      = 19'd500000;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEAREST = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic decide;
        logic out_load;
    } pfan_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cnt_zero;
        logic scan_last;
        logic pipe_busy;
    } pfan_sts_t;

endpackage

### sv/pfan_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pfan_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/pfan_ctrl.sv
// Controller state machine for the palette core: sequences load, scan,
// drain, decide and output. Depends on pfan_pkg and the assertion header.
`timescale 1ns / 1ps
`include "palette_find_add_nearest_core_assert.svh"

module pfan_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pfan_pkg::pfan_sts_t sts,
    output pfan_pkg::pfan_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `PFAN_ASSERT_IMP(a_idle_drained, state_reg == ST_IDLE, !sts.pipe_busy, "scan pipe busy in idle")
    `PFAN_ASSERT_IMP(a_decide_drained, cmd.decide, !sts.pipe_busy, "decide before scan drained")
    `PFAN_ASSERT_NXT(a_finish_waits, state_reg == ST_FINISH && out_valid_reg && !out_ready, state_reg == ST_FINISH, "result slot overwritten")

endmodule

### sv/pfan_dp.sv
// Datapath for the palette core: palette RAM, scan pipeline with exact match
// and squared RGB distance, entry count, limit register and result words.
// Depends on pfan_pkg, pfan_ram and the assertion header.
`timescale 1ns / 1ps
`include "palette_find_add_nearest_core_assert.svh"

module pfan_dp #(
    parameter int PALETTE_DEPTH = pfan_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pfan_pkg::pfan_cmd_t                cmd,
    output pfan_pkg::pfan_sts_t                sts,
    input  logic [pfan_pkg::COLOR_W-1:0]       in_color,
    input  logic                               in_clear,
    input  logic                               cfg_we,
    input  logic [pfan_pkg::LIMIT_W-1:0]       cfg_limit,
    output logic [pfan_pkg::IDX_OUT_W-1:0]     out_idx,
    output logic [pfan_pkg::KIND_W-1:0]        out_kind,
    output logic [pfan_pkg::CNT_OUT_W-1:0]     out_cnt
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > pfan_pkg::LIMIT_W) ? CNT_W : pfan_pkg::LIMIT_W;
    localparam int EXT_W = (IDX_W > pfan_pkg::IDX_OUT_W) ? IDX_W : pfan_pkg::IDX_OUT_W;

    // Control state
    logic [pfan_pkg::LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         rd_vld_reg;
    logic                         sq_vld_reg;

    // Payload
    logic [pfan_pkg::COLOR_W-1:0] color_reg;
    logic [IDX_W-1:0]             addr_reg;
    logic [IDX_W-1:0]             rd_idx_reg;
    logic [IDX_W-1:0]             sq_idx_reg;
    logic [15:0]                  sq_r_reg;
    logic [15:0]                  sq_g_reg;
    logic [15:0]                  sq_b_reg;
    logic                         eq_reg;
    logic                         found_reg;
    logic [IDX_W-1:0]             match_idx_reg;
    logic [pfan_pkg::DIST_W-1:0]  best_reg;
    logic [IDX_W-1:0]             near_idx_reg;
    logic [IDX_W-1:0]             res_idx_reg;
    logic [pfan_pkg::KIND_W-1:0]  res_kind_reg;
    logic [CNT_W-1:0]             res_cnt_reg;
    logic [pfan_pkg::IDX_OUT_W-1:0] out_idx_reg;
    logic [pfan_pkg::KIND_W-1:0]  out_kind_reg;
    logic [pfan_pkg::CNT_OUT_W-1:0] out_cnt_reg;

    logic [pfan_pkg::COLOR_W-1:0] ram_q;
    logic [7:0]                   d_r;
    logic [7:0]                   d_g;
    logic [7:0]                   d_b;
    logic [pfan_pkg::DIST_W-1:0]  dist_sum;
    logic [CMP_W-1:0]             eff_limit;
    logic                         add_new;
    logic [EXT_W-1:0]             idx_ext;
    logic [CMP_W-1:0]             cnt_ext;

    pfan_ram #(
        .WIDTH (pfan_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.decide && add_new),
        .waddr (IDX_W'(count_reg)),
        .wdata (color_reg),
        .re    (cmd.step),
        .raddr (addr_reg),
        .rdata (ram_q)
    );

    // Per-channel absolute differences of the stored entry
    always_comb
    begin
        d_r = (ram_q[23:16] > color_reg[23:16]) ? ram_q[23:16] - color_reg[23:16]
                                                : color_reg[23:16] - ram_q[23:16];
        d_g = (ram_q[15:8] > color_reg[15:8]) ? ram_q[15:8] - color_reg[15:8]
                                              : color_reg[15:8] - ram_q[15:8];
        d_b = (ram_q[7:0] > color_reg[7:0]) ? ram_q[7:0] - color_reg[7:0]
                                            : color_reg[7:0] - ram_q[7:0];
    end

    // Sum of squares from the registered products
    assign dist_sum = pfan_pkg::DIST_W'(sq_r_reg) + pfan_pkg::DIST_W'(sq_g_reg)
                    + pfan_pkg::DIST_W'(sq_b_reg);

    // Clamp the limit to the storage and decide whether to append
    always_comb
    begin
        eff_limit = CMP_W'(limit_reg);
        if (CMP_W'(limit_reg) > CMP_W'(PALETTE_DEPTH))
        begin
            eff_limit = CMP_W'(PALETTE_DEPTH);
        end
        add_new = !found_reg && (CMP_W'(count_reg) < eff_limit);
    end

    // Entry count update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.load && in_clear)
        begin
            count_next = '0;
        end
        else if (cmd.decide && add_new)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= pfan_pkg::LIMIT_RESET;
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_limit;
            end
            count_reg  <= count_next;
            rd_vld_reg <= cmd.step;
            sq_vld_reg <= rd_vld_reg;
        end
    end

    // Scan pipeline, search results and output word
    always_ff @(posedge clk)
    begin
        // Latch request and restart the search
        if (cmd.load)
        begin
            color_reg    <= in_color;
            addr_reg     <= '0;
            found_reg    <= 1'b0;
            best_reg     <= pfan_pkg::DIST_CEILING;
            near_idx_reg <= '0;
        end
        else if (cmd.step)
        begin
            addr_reg <= addr_reg + IDX_W'(1);
        end
        rd_idx_reg <= addr_reg;

        // Square the channel differences
        sq_idx_reg <= rd_idx_reg;
        eq_reg     <= (ram_q == color_reg);
        sq_r_reg   <= 16'(d_r) * 16'(d_r);
        sq_g_reg   <= 16'(d_g) * 16'(d_g);
        sq_b_reg   <= 16'(d_b) * 16'(d_b);

        // Keep the first exact match and the earliest strict minimum
        if (sq_vld_reg)
        begin
            if (eq_reg && !found_reg)
            begin
                found_reg     <= 1'b1;
                match_idx_reg <= sq_idx_reg;
            end
            if (dist_sum < best_reg)
            begin
                best_reg     <= dist_sum;
                near_idx_reg <= sq_idx_reg;
            end
        end

        // Resolve the request
        if (cmd.decide)
        begin
            res_cnt_reg <= count_next;
            priority if (found_reg)
            begin
                res_idx_reg  <= match_idx_reg;
                res_kind_reg <= pfan_pkg::KIND_MATCH;
            end
            else if (add_new)
            begin
                res_idx_reg  <= IDX_W'(count_reg);
                res_kind_reg <= pfan_pkg::KIND_ADDED;
            end
            else
            begin
                res_idx_reg  <= near_idx_reg;
                res_kind_reg <= pfan_pkg::KIND_NEAREST;
            end
        end

        // Move the result into the output word
        if (cmd.out_load)
        begin
            out_idx_reg  <= idx_ext[pfan_pkg::IDX_OUT_W-1:0];
            out_kind_reg <= res_kind_reg;
            out_cnt_reg  <= cnt_ext[pfan_pkg::CNT_OUT_W-1:0];
        end
    end

    assign idx_ext = EXT_W'(res_idx_reg);
    assign cnt_ext = CMP_W'(res_cnt_reg);

    assign sts.cnt_zero  = (count_reg == '0);
    assign sts.scan_last = ((CNT_W'(addr_reg) + CNT_W'(1)) == count_reg);
    assign sts.pipe_busy = rd_vld_reg || sq_vld_reg;

    assign out_idx  = out_idx_reg;
    assign out_kind = out_kind_reg;
    assign out_cnt  = out_cnt_reg;

    `PFAN_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(PALETTE_DEPTH), "entry count past depth")
    `PFAN_ASSERT_NXT(a_append_counts, cmd.decide && add_new, count_reg == $past(count_reg) + CNT_W'(1), "append did not count")
    `PFAN_ASSERT_NXT(a_load_restarts, cmd.load, addr_reg == '0 && !found_reg, "search not restarted on load")

endmodule

### sv/palette_find_add_nearest_core.sv
// Palette find/add/nearest core: maps each 24-bit RGB word to a palette index.
// Words are taken one at a time: a new word is accepted only once the previous
// result has moved into the output word. The RAM is scanned one entry per cycle
// through its single read port, then drained, resolved and output. Reset (rst_n
// low, async): palette empty, limit 256.
`timescale 1ns / 1ps

module palette_find_add_nearest_core #(
    parameter int PALETTE_DEPTH = pfan_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [pfan_pkg::TDATA_IN_W-1:0]      s_axis_tdata,  // [23:0] rgb_color
    input  logic                                 s_axis_tuser,  // [0] clear_first
    // Output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [pfan_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,  // [7:0] palette_index,
                                                                // [16:8] entry_count
    output logic [pfan_pkg::KIND_W-1:0]          m_axis_tuser,  // [1:0] match_kind
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pfan_pkg::LIMIT_W-1:0]         cfg_data       // color_limit
);

    localparam int PAD_W = pfan_pkg::TDATA_OUT_W - pfan_pkg::IDX_OUT_W - pfan_pkg::CNT_OUT_W;

    pfan_pkg::pfan_cmd_t              cmd;
    pfan_pkg::pfan_sts_t              sts;
    logic [pfan_pkg::IDX_OUT_W-1:0]   out_idx;
    logic [pfan_pkg::CNT_OUT_W-1:0]   out_cnt;

    pfan_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pfan_dp #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_color  (s_axis_tdata[pfan_pkg::COLOR_W-1:0]),
        .in_clear  (s_axis_tuser),
        .cfg_we    (cfg_valid),
        .cfg_limit (cfg_data),
        .out_idx   (out_idx),
        .out_kind  (m_axis_tuser),
        .out_cnt   (out_cnt)
    );

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    // Pack the output word
    assign m_axis_tdata = {{PAD_W{1'b0}}, out_cnt, out_idx};

endmodule

### sim/palette_lookup_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the palette find/add/nearest core: keeps a shadow palette,
// predicts the result word of every accepted color and compares on output.
// Depends on pfan_pkg for field widths and result kinds.

module palette_lookup_checker #(
    parameter int PALETTE_DEPTH = pfan_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream as seen by the core
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [pfan_pkg::TDATA_IN_W-1:0]     s_data,   // [23:0] rgb_color
    input  logic                                s_user,   // [0] clear_first
    // Output stream as seen by the core
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [pfan_pkg::TDATA_OUT_W-1:0]    m_data,   // [7:0] palette_index,
                                                          // [16:8] entry_count
    input  logic [pfan_pkg::KIND_W-1:0]         m_user,   // [1:0] match_kind
    // Configuration channel
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pfan_pkg::LIMIT_W-1:0]        cfg_data,
    // Status toward the stimulus side
    output int                                  outstanding,
    output int                                  failures
);

    localparam int IW = pfan_pkg::IDX_OUT_W;
    localparam int CW = pfan_pkg::CNT_OUT_W;

    typedef struct packed {
        logic [IW-1:0]               pal_index;
        logic [pfan_pkg::KIND_W-1:0] kind;
        logic [CW-1:0]               entries;
    } lookup_result_t;

    logic [pfan_pkg::COLOR_W-1:0] shadow_palette [PALETTE_DEPTH];
    int                           shadow_count;
    int                           shadow_limit;
    lookup_result_t               expected_lookups [$];

    // Squared distance with per-channel differences
    function automatic int color_distance(input logic [23:0] a, input logic [23:0] b);
        int dr;
        int dg;
        int db;
        dr = int'(a[23:16]) - int'(b[23:16]);
        dg = int'(a[15:8]) - int'(b[15:8]);
        db = int'(a[7:0]) - int'(b[7:0]);
        return dr * dr + dg * dg + db * db;
    endfunction

    // Look up one color against the shadow palette and update it
    task automatic resolve_color(input logic [23:0] color, input logic clr,
                                 output lookup_result_t res);
        int  eff_limit;
        int  best;
        int  cand_dist;
        bit  found;
        res.pal_index = '0;
        res.kind      = pfan_pkg::KIND_NEAREST;
        found         = 1'b0;
        if (clr)
            shadow_count = 0;
        eff_limit = (shadow_limit > PALETTE_DEPTH) ? PALETTE_DEPTH : shadow_limit;

        // First exact occurrence wins
        for (int i = 0; i < shadow_count && !found; i++)
        begin
            if (shadow_palette[i] == color)
            begin
                res.pal_index = IW'(i);
                res.kind      = pfan_pkg::KIND_MATCH;
                found         = 1'b1;
            end
        end

        if (!found)
        begin
            if (shadow_count < eff_limit)
            begin
                // Append while room is left
                shadow_palette[shadow_count] = color;
                res.pal_index = IW'(shadow_count);
                res.kind      = pfan_pkg::KIND_ADDED;
                shadow_count++;
            end
            else
            begin
                // Full table: strictly smaller distance moves the choice
                best = int'(pfan_pkg::DIST_CEILING);
                for (int i = 0; i < shadow_count; i++)
                begin
                    cand_dist = color_distance(color, shadow_palette[i]);
                    if (cand_dist < best)
                    begin
                        best          = cand_dist;
                        res.pal_index = IW'(i);
                    end
                end
            end
        end
        res.entries = CW'(shadow_count);
    endtask

    // Track configuration, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin : track
        lookup_result_t got;
        lookup_result_t want;
        lookup_result_t fresh;
        int             errs;
        if (!rst_n)
        begin
            shadow_count = 0;
            shadow_limit = int'(pfan_pkg::LIMIT_RESET);
            expected_lookups.delete();
            outstanding <= 0;
            failures    <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_valid && cfg_ready)
                shadow_limit = int'(cfg_data);

            // Check the result word before queuing a new prediction
            if (m_valid && m_ready)
            begin
                got.pal_index = m_data[IW-1:0];
                got.entries   = m_data[IW +: CW];
                got.kind      = m_user;
                if (expected_lookups.size() == 0)
                begin
                    $error("unexpected result word: palette_index %0d match_kind %0d entry_count %0d",
                           got.pal_index, got.kind, got.entries);
                    errs++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (got.pal_index !== want.pal_index)
                    begin
                        $error("palette_index: expected %0d, actual %0d",
                               want.pal_index, got.pal_index);
                        errs++;
                    end
                    if (got.kind !== want.kind)
                    begin
                        $error("match_kind: expected %0d, actual %0d", want.kind, got.kind);
                        errs++;
                    end
                    if (got.entries !== want.entries)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entries, got.entries);
                        errs++;
                    end
                    if (m_data[pfan_pkg::TDATA_OUT_W-1:IW+CW] !== '0)
                    begin
                        $error("tdata padding: expected 0, actual %0h",
                               m_data[pfan_pkg::TDATA_OUT_W-1:IW+CW]);
                        errs++;
                    end
                end
            end

            if (s_valid && s_ready)
            begin
                resolve_color(s_data[pfan_pkg::COLOR_W-1:0], s_user, fresh);
                expected_lookups.push_back(fresh);
            end

            failures    <= failures + errs;
            outstanding <= expected_lookups.size();
        end
    end

endmodule

### sim/palette_find_add_nearest_core_tb.sv
`timescale 1ns / 1ps
// Top of the palette core testbench: clock, reset, stimulus and verdict.
// Depends on pfan_pkg, palette_find_add_nearest_core and palette_lookup_checker.

module palette_find_add_nearest_core_tb;

    // Idle modes for the two stream sides
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    localparam int HOLD_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 300;
    localparam int HISTORY_LEN = 48;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [pfan_pkg::TDATA_IN_W-1:0]     s_axis_tdata = '0;   // [23:0] rgb_color
    logic                                s_axis_tuser = 1'b0; // [0] clear_first
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [pfan_pkg::TDATA_OUT_W-1:0]    m_axis_tdata;        // [7:0] palette_index,
                                                              // [16:8] entry_count
    logic [pfan_pkg::KIND_W-1:0]         m_axis_tuser;        // [1:0] match_kind
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [pfan_pkg::LIMIT_W-1:0]        cfg_data = '0;

    int   outstanding;
    int   failures;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_active = 1'b0;
    event hold_start;

    logic [pfan_pkg::COLOR_W-1:0] sent_colors [$];

    palette_find_add_nearest_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    palette_lookup_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_data      (s_axis_tdata),
        .s_user      (s_axis_tuser),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_data      (m_axis_tdata),
        .m_user      (m_axis_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .failures    (failures)
    );

    // Free-running clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Count out a long receiver hold-off
    initial
    begin
        forever
        begin
            @(hold_start);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    // Drive the output-side ready with random stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            m_axis_tready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic set_idle_mode(input int mode);
        case (mode)
            IDLE_SEND: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            IDLE_BOTH: begin send_idle_pct = 27; recv_stall_pct = 27; end
            default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Offer one color word and hold it until accepted
    task automatic send_color(input logic [23:0] color, input logic clr);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= color;
        s_axis_tuser  <= clr;
        do @(posedge clk); while (!s_axis_tready);
        sent_colors.push_back(color);
        if (sent_colors.size() > HISTORY_LEN)
            void'(sent_colors.pop_front());
    endtask

    // Drain all results, then write color_limit
    task automatic write_limit(input logic [pfan_pkg::LIMIT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Fresh color, a repeat of a recent one, or a near neighbor of one
    function automatic logic [23:0] pick_color(input int fresh_pct);
        int          roll;
        logic [23:0] base;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        roll = $urandom_range(0, 99);
        if (sent_colors.size() == 0 || roll < fresh_pct)
            return 24'($urandom());
        base = sent_colors[$urandom_range(0, sent_colors.size() - 1)];
        if (roll < fresh_pct + (100 - fresh_pct) / 2)
            return base;
        r = base[23:16] + 8'($urandom_range(0, 6)) - 8'd3;
        g = base[15:8] + 8'($urandom_range(0, 6)) - 8'd3;
        b = base[7:0] + 8'($urandom_range(0, 6)) - 8'd3;
        return {r, g, b};
    endfunction

    task automatic run_phase(input logic [pfan_pkg::LIMIT_W-1:0] limit, input int items,
                             input int clear_pct, input int fresh_pct, input int mode,
                             input bit hold);
        write_limit(limit);
        set_idle_mode(mode);
        if (hold)
            -> hold_start;
        for (int n = 0; n < items; n++)
            send_color(pick_color(fresh_pct), $urandom_range(0, 99) < clear_pct);
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: add, exact match, clear
        set_idle_mode(IDLE_NONE);
        send_color(24'h000000, 1'b0);
        send_color(24'hFFFFFF, 1'b0);
        send_color(24'h000000, 1'b0);
        send_color(24'hFFFFFF, 1'b0);
        send_color(24'h123456, 1'b1);

        // Small limit: nearest substitute and tie to the earliest entry
        write_limit(9'd2);
        send_color(24'h000000, 1'b1);
        send_color(24'h020000, 1'b0);
        send_color(24'h010000, 1'b0);
        send_color(24'h020000, 1'b0);
        send_color(24'hFFFFFF, 1'b0);

        // Zero limit: full and empty table
        write_limit(9'd0);
        send_color(24'hABCDEF, 1'b1);
        send_color(24'h00FF00, 1'b0);

        // Fill six entries, then lower the limit below the count
        write_limit(9'd256);
        send_color(24'h0000FF, 1'b1);
        send_color(24'h00FF00, 1'b0);
        send_color(24'hFF0000, 1'b0);
        send_color(24'h808080, 1'b0);
        send_color(24'h7F7F7F, 1'b0);
        send_color(24'hFFFFFE, 1'b0);
        write_limit(9'd3);
        send_color(24'h808081, 1'b0);
        send_color(24'hFFFFFE, 1'b0);
        send_color(24'h010203, 1'b1);

        // Oversized limit
        write_limit(9'd511);
        send_color(24'h5A5A5A, 1'b1);
        send_color(24'hA5A5A5, 1'b0);

        // Random phases: limit, items, clear %, fresh %, idle mode, hold-off
        run_phase(9'd256, 400, 0, 80, IDLE_NONE, 1'b0);
        run_phase(9'd16,  150, 4, 40, IDLE_SEND, 1'b0);
        run_phase(9'd0,    60, 5, 50, IDLE_RECV, 1'b0);
        run_phase(9'd1,   100, 5, 40, IDLE_BOTH, 1'b0);
        run_phase(9'd2,   100, 5, 40, IDLE_NONE, 1'b1);
        run_phase(9'd7,   150, 4, 40, IDLE_SEND, 1'b0);
        run_phase(9'd40,  150, 2, 50, IDLE_RECV, 1'b0);
        run_phase(9'd255, 120, 1, 60, IDLE_BOTH, 1'b0);
        run_phase(9'd511, 100, 3, 50, IDLE_NONE, 1'b0);
        run_phase(9'd300, 100, 3, 50, IDLE_SEND, 1'b0);
        run_phase(9'd3,   150, 4, 40, IDLE_RECV, 1'b0);
        run_phase(9'd9,   150, 4, 40, IDLE_BOTH, 1'b0);
        run_phase(9'd256, 120, 5, 50, IDLE_NONE, 1'b0);

        // Drain and let any stray word show up
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
